FILE: sv/apt_pkg.sv
// Shared types, constants and codes for the pheromone table update block.
// Used by apt_recip_div, apt_row_store and ant_pheromone_table_update.
package apt_pkg;

  localparam int DEST_COUNT = 256;
  localparam int GATE_COUNT = 8;
  localparam int FRAC_BITS  = 16;

  localparam int ROW_W  = $clog2(DEST_COUNT);
  localparam int GATE_W = $clog2(GATE_COUNT);
  localparam int GN_W   = $clog2(GATE_COUNT + 1);
  localparam int ADDR_W = ROW_W + GATE_W;
  localparam int DEPTH  = DEST_COUNT * GATE_COUNT;

  // Pheromone values are unsigned Q1.FRAC_BITS.
  localparam int PH_W = FRAC_BITS + 1;
  localparam logic [PH_W-1:0] PH_MAX = {PH_W{1'b1}};

  localparam int FACT_W = 16;
  localparam int COST_W = 16;
  localparam int HOP_W  = 8;
  localparam int SUM_W  = COST_W + 1;
  localparam int GC_W   = FACT_W + 1 + SUM_W;
  localparam int DEN_W  = COST_W + HOP_W + 1;
  localparam int NUM_W  = GC_W + FRAC_BITS - 16;
  // Every quotient the block needs is at most one in Q1.FRAC_BITS.
  localparam int QUO_W  = PH_W;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_EVAP_FACTOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_METRIC_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GATES_IN_USE = 2'd2;

  localparam logic [1:0] MODE_TIME = 2'd0;
  localparam logic [1:0] MODE_HOPS = 2'd1;

  localparam logic CMD_REINFORCE = 1'b0;
  localparam logic CMD_INIT      = 1'b1;

  localparam logic [FACT_W-1:0] EVAP_RESET  = 16'd58982;
  localparam logic [1:0]        MODE_RESET  = MODE_TIME;
  localparam logic [3:0]        GATES_RESET = 4'd8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_START,
    S_RD,
    S_MUL,
    S_WR,
    S_INIT_WAIT,
    S_INIT_WR,
    S_DONE
  } apt_state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } apt_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } apt_div_rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PH_W-1:0]   wdata;
    logic              mark;
  } apt_mem_req_t;

endpackage

FILE: sv/apt_recip_div.sv
// Restoring divider, one quotient bit per cycle, for the reward and init values.
// Depends on apt_pkg for widths and the request and response structs.
module apt_recip_div (
  input  logic                  clk,
  input  logic                  rst,
  input  apt_pkg::apt_div_req_t req,
  output apt_pkg::apt_div_rsp_t rsp
);
  import apt_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [QUO_W-1:0] nbits;
  logic [QUO_W-1:0] quot;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;

  // The quotient never exceeds QUO_W bits, so the upper numerator bits form
  // the starting remainder and only the low QUO_W bits are shifted in.
  always_comb begin
    trial = {rem, nbits[QUO_W-1]};
    ge    = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == CNT_LAST) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt   <= '0;
      rem   <= DEN_W'(req.num >> QUO_W);
      nbits <= req.num[QUO_W-1:0];
      den   <= req.den;
      quot  <= '0;
    end else if (busy) begin
      cnt   <= cnt + 1'b1;
      rem   <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nbits <= nbits << 1;
      quot  <= {quot[QUO_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

FILE: sv/apt_row_store.sv
// Pheromone table memory with one valid bit per destination row.
// Depends on apt_pkg; a row that was never written reads as zero.
module apt_row_store (
  input  logic                  clk,
  input  logic                  rst,
  input  apt_pkg::apt_mem_req_t req,
  output logic [apt_pkg::PH_W-1:0] rdata
);
  import apt_pkg::*;

  logic [PH_W-1:0]       mem [DEPTH];
  logic [PH_W-1:0]       mem_q;
  logic [DEST_COUNT-1:0] row_valid;
  logic                  valid_q;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    mem_q <= mem[req.raddr];
  end

  // A row is marked once its last entry has been written, so reads earlier in
  // the same walk still see the cleared row.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= row_valid[req.raddr[ADDR_W-1:GATE_W]];
      if (req.we && req.mark) begin
        row_valid[req.waddr[ADDR_W-1:GATE_W]] <= 1'b1;
      end
    end
  end

  assign rdata = valid_q ? mem_q : '0;

endmodule

FILE: sv/ant_pheromone_table_update.sv
// Pheromone table update: sequencer, configuration registers and output word.
// Depends on apt_pkg, apt_recip_div and apt_row_store.
//
// Input words (in_valid/in_ready) carry a command, a destination row, a gate
// and the path's travel cost and hop count. Each accepted word gives exactly
// one output word (out_valid/out_ready) holding the new pheromone value of
// the reinforced gate, or the uniform value written by an init command.
// A reinforce word walks all gates of its row, taking each through memory
// read, evaporation multiply and write back, while the 17-step reward
// division runs in the background. When the chosen gate is 5 or above the
// walk never waits for the divider; a lower gate holds its write back until
// the quotient is ready. An init word waits for the divider and then writes
// the row. Words whose row or gate lies outside the table would finish with 0
// without walking the row, but the port widths cover the table, so none can.
// One word is worked on at a time; in_ready is high whenever the sequencer is
// idle, from the cycle out_valid rises. If the receiver stalls, the finished
// result waits. Reset (rst, synchronous) restores the configuration defaults
// and clears the row valid bits at once, so the whole table reads as zero
// immediately. The user must write configuration through
// cfg_write/cfg_index/cfg_data only while idle; the block does not enforce it.
module ant_pheromone_table_update (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [apt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apt_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic [7:0]                     dest_addr,
  input  logic [2:0]                     chosen_gate,
  input  logic [15:0]                    travel_cost,
  input  logic [7:0]                     hop_total,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [16:0]                    new_pheromone
);
  import apt_pkg::*;

  localparam logic [GATE_W-1:0] GATE_LAST = GATE_W'(GATE_COUNT - 1);
  localparam int PROD_W = PH_W + FACT_W;
  localparam int WIDE_W = NUM_W + 16;

  apt_state_t state, state_next;

  logic [FACT_W-1:0] evap_factor;
  logic [1:0]        metric_mode;
  logic [3:0]        gates_in_use;

  logic              cmd_q;
  logic [ROW_W-1:0]  row_q;
  logic [GATE_W-1:0] gate_q;
  logic [COST_W-1:0] cost_q;
  logic [HOP_W-1:0]  hops_q;
  logic [GATE_W-1:0] gidx;
  logic [GC_W-1:0]   gc_q;
  logic [DEN_W-1:0]  ch2_q;
  logic [PH_W-1:0]   old_q;
  logic [PROD_W-1:0] prod_q;
  logic [PH_W-1:0]   result_q;

  apt_div_req_t div_req;
  apt_div_rsp_t div_rsp;
  apt_mem_req_t mem_req;
  logic [PH_W-1:0] rdata;

  logic              accept;
  logic              skip_item;
  logic [GN_W-1:0]   n_eff;
  logic [FACT_W:0]   g_comp;
  logic [WIDE_W-1:0] g_wide;
  logic [WIDE_W-1:0] gc_wide;
  logic [PH_W-1:0]   evap_val;
  logic [PH_W:0]     sum_val;
  logic [PH_W-1:0]   sat_val;
  logic              in_use;
  logic              is_chosen;
  logic              last_gate;
  logic              out_free;
  logic [PH_W-1:0]   wr_val;

  apt_recip_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  apt_row_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      evap_factor  <= EVAP_RESET;
      metric_mode  <= MODE_RESET;
      gates_in_use <= GATES_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_EVAP_FACTOR:  evap_factor  <= cfg_data;
        CFG_METRIC_MODE:  metric_mode  <= cfg_data[1:0];
        CFG_GATES_IN_USE: gates_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    accept    = in_valid && in_ready;
    skip_item = (32'(dest_addr) >= DEST_COUNT) ||
                (command == CMD_REINFORCE && 32'(chosen_gate) >= GATE_COUNT);
    n_eff     = (32'(gates_in_use) > GATE_COUNT) ? GN_W'(GATE_COUNT)
                                                 : GN_W'(gates_in_use);
    g_comp    = 17'd65536 - {1'b0, evap_factor};
    g_wide    = WIDE_W'(g_comp) << FRAC_BITS;
    gc_wide   = WIDE_W'(gc_q) << FRAC_BITS;
    evap_val  = PH_W'(prod_q >> 16);
    sum_val   = {1'b0, evap_val} + {1'b0, div_rsp.quot};
    sat_val   = sum_val[PH_W] ? PH_MAX : sum_val[PH_W-1:0];
    in_use    = GN_W'(gidx) < n_eff;
    is_chosen = gidx == gate_q;
    last_gate = gidx == GATE_LAST;
    out_free  = !out_valid || out_ready;
    if (is_chosen) begin
      wr_val = sat_val;
    end else if (in_use) begin
      wr_val = evap_val;
    end else begin
      wr_val = old_q;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (accept) state_next = skip_item ? S_DONE : S_PREP;
      S_PREP:      state_next = S_START;
      S_START:     state_next = (cmd_q == CMD_INIT) ? S_INIT_WAIT : S_RD;
      S_RD:        state_next = S_MUL;
      S_MUL:       state_next = S_WR;
      S_WR: begin
        if (!is_chosen || div_rsp.done) begin
          state_next = last_gate ? S_DONE : S_RD;
        end
      end
      S_INIT_WAIT: if (div_rsp.done) state_next = S_INIT_WR;
      S_INIT_WR:   if (last_gate) state_next = S_DONE;
      S_DONE:      if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = state == S_IDLE;
    div_req.start = state == S_START;
    div_req.num   = NUM_W'(g_wide >> 16);
    div_req.den   = DEN_W'(cost_q);
    if (cmd_q == CMD_INIT) begin
      div_req.num = NUM_W'(1) << FRAC_BITS;
      div_req.den = (n_eff == '0) ? DEN_W'(1) : DEN_W'(n_eff);
    end else if (metric_mode == MODE_TIME) begin
      div_req.num = NUM_W'(g_wide >> 16);
      div_req.den = DEN_W'(cost_q);
    end else if (metric_mode == MODE_HOPS) begin
      // A single hop divides by one and so yields the learning share itself.
      div_req.num = (hops_q > HOP_W'(1)) ? (NUM_W'(1) << FRAC_BITS)
                                         : NUM_W'(g_wide >> 16);
      div_req.den = DEN_W'(hops_q);
    end else begin
      div_req.num = NUM_W'(gc_wide >> 16);
      div_req.den = ch2_q;
    end

    mem_req.raddr = {row_q, gidx};
    mem_req.waddr = {row_q, gidx};
    mem_req.we    = 1'b0;
    mem_req.wdata = wr_val;
    mem_req.mark  = last_gate;
    unique case (state)
      S_WR:      mem_req.we = !is_chosen || div_rsp.done;
      S_INIT_WR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = in_use ? div_rsp.quot : '0;
      end
      default:   mem_req.we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= command;
      row_q    <= ROW_W'(dest_addr);
      gate_q   <= GATE_W'(chosen_gate);
      cost_q   <= (travel_cost == '0) ? COST_W'(1) : travel_cost;
      hops_q   <= (hop_total == '0) ? HOP_W'(1) : hop_total;
      gidx     <= '0;
      result_q <= '0;
    end
    if (state == S_PREP) begin
      gc_q  <= GC_W'(g_comp * ({1'b0, cost_q} + SUM_W'(hops_q)));
      ch2_q <= DEN_W'({cost_q, 1'b0}) * DEN_W'(hops_q);
    end
    if (state == S_MUL) begin
      old_q  <= rdata;
      prod_q <= rdata * evap_factor;
    end
    if (mem_req.we) begin
      gidx <= gidx + 1'b1;
    end
    if (state == S_WR && is_chosen && div_rsp.done) begin
      result_q <= sat_val;
    end
    if (state == S_INIT_WR && last_gate) begin
      result_q <= div_rsp.quot;
    end
    if (state == S_DONE && out_free) begin
      new_pheromone <= 17'(result_q);
    end
  end

endmodule
